### sv/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// shared types and constants for the linear probing hash table unit
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int KEY_W  = 31;
    localparam int MOD_W  = 7;
    localparam int SLOT_W = 6;

    localparam logic [MOD_W-1:0] HASH_MODULUS_RESET = 7'd64;

    typedef enum logic
    {
        CMD_INSERT = 1'b0,
        CMD_DELETE = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        SLOT_EMPTY = 2'd0,
        SLOT_USED  = 2'd1,
        SLOT_GONE  = 2'd2
    } slot_state_t;

    typedef enum logic [1:0]
    {
        RES_INSERTED = 2'd0,
        RES_FULL     = 2'd1,
        RES_DELETED  = 2'd2,
        RES_MISSING  = 2'd3
    } result_t;

    // write side of the slot store
    typedef struct packed
    {
        logic        we_status;
        logic        we_key;
        slot_state_t status;
    } slot_wr_t;

endpackage

### sv/lpht_ifs.sv
// ----------------------------------------------------------------------------
// lpht channel interfaces
// valid/ready channels for requests, responses and the modulus register
// ----------------------------------------------------------------------------
interface lpht_req_if;
    logic                          valid;
    logic                          ready;
    lpht_pkg::cmd_t                cmd;
    logic [lpht_pkg::KEY_W-1:0]    key;

    modport source (output valid, output cmd, output key, input ready);
    modport sink   (input valid, input cmd, input key, output ready);
endinterface

interface lpht_rsp_if;
    logic                          valid;
    logic                          ready;
    lpht_pkg::result_t             status;
    logic [lpht_pkg::SLOT_W-1:0]   slot;

    modport source (output valid, output status, output slot, input ready);
    modport sink   (input valid, input status, input slot, output ready);
endinterface

interface lpht_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lpht_pkg::MOD_W-1:0]    hash_modulus;

    modport source (output valid, output hash_modulus, input ready);
    modport sink   (input valid, input hash_modulus, output ready);
endinterface

### sv/lpht_mod_unit.sv
// ----------------------------------------------------------------------------
// lpht_mod_unit
// bit-serial remainder of the key by the effective divisor, one bit a cycle
// ----------------------------------------------------------------------------
module lpht_mod_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lpht_pkg::KEY_W-1:0]    key,
    input  logic [lpht_pkg::MOD_W-1:0]    divisor,
    output logic                          done,
    output logic [lpht_pkg::MOD_W-1:0]    rem
);

    localparam int CNT_W = $clog2(lpht_pkg::KEY_W);

    logic                          busy_reg;
    logic                          done_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [lpht_pkg::KEY_W-1:0]    key_sh_reg;
    logic [lpht_pkg::MOD_W-1:0]    div_reg;
    logic [lpht_pkg::MOD_W-1:0]    rem_reg;
    logic [lpht_pkg::MOD_W-1:0]    shifted;
    logic [lpht_pkg::MOD_W-1:0]    rem_next;

    // remainder stays below the divisor, so it fits in one bit less
    assign shifted  = {rem_reg[lpht_pkg::MOD_W-2:0], key_sh_reg[lpht_pkg::KEY_W-1]};
    assign rem_next = (shifted >= div_reg) ? (shifted - div_reg) : shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= CNT_W'(cnt_reg + 1'b1);
                if (cnt_reg == CNT_W'(lpht_pkg::KEY_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            key_sh_reg <= key;
            div_reg    <= divisor;
            rem_reg    <= '0;
        end
        else if (busy_reg)
        begin
            key_sh_reg <= {key_sh_reg[lpht_pkg::KEY_W-2:0], 1'b0};
            rem_reg    <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

### sv/lpht_slot_store.sv
// ----------------------------------------------------------------------------
// lpht_slot_store
// per-slot status and key memories, one write and one registered read port
// ----------------------------------------------------------------------------
module lpht_slot_store
#(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
)
(
    input  logic                          clk,
    input  logic [IDX_W-1:0]              rd_addr,
    output lpht_pkg::slot_state_t         rd_status,
    output logic [lpht_pkg::KEY_W-1:0]    rd_key,
    input  logic [IDX_W-1:0]              wr_addr,
    input  lpht_pkg::slot_wr_t            wr,
    input  logic [lpht_pkg::KEY_W-1:0]    wr_key
);

    lpht_pkg::slot_state_t         status_mem [DEPTH];
    logic [lpht_pkg::KEY_W-1:0]    key_mem    [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.we_status)
        begin
            status_mem[wr_addr] <= wr.status;
        end
        if (wr.we_key)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        rd_status <= status_mem[rd_addr];
        rd_key    <= key_mem[rd_addr];
    end

endmodule

### sv/linear_probe_hash_table_unit.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit
// open-addressing hash table with linear probing and deleted-slot markers
// ----------------------------------------------------------------------------
// One request item at a time: insert or delete a key. The home slot is the key
// modulo the effective divisor (hash_modulus, 0 acting as 1, capped at
// TABLE_DEPTH), found by a bit-serial remainder unit. The probe then reads
// one slot per cycle from the status/key memories, wrapping at the divisor,
// for at most TABLE_DEPTH slots, and writes the slot back when it lands.
// After reset a clearing pass marks every slot empty, and no request is
// taken meanwhile (modulus writes are). The response register frees the
// engine, so a new request can start while the last response waits to be
// taken.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_unit
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    lpht_req_if.sink    req,
    lpht_rsp_if.source  rsp,
    lpht_cfg_if.sink    cfg
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int MOD_W = lpht_pkg::MOD_W;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_PROBE,
        ST_DONE
    } state_t;

    // control registers
    state_t                        state_reg,        state_next;
    logic [CNT_W-1:0]              cnt_reg,          cnt_next;
    logic [MOD_W-1:0]              pos_reg,          pos_next;
    logic [MOD_W-1:0]              hash_modulus_reg;
    logic                          rsp_valid_reg,    rsp_valid_next;

    // payload registers
    lpht_pkg::cmd_t                cmd_reg;
    logic [lpht_pkg::KEY_W-1:0]    key_reg;
    lpht_pkg::result_t             res_status_reg,   res_status_next;
    logic [lpht_pkg::SLOT_W-1:0]   res_slot_reg,     res_slot_next;
    lpht_pkg::result_t             rsp_status_reg,   rsp_status_next;
    logic [lpht_pkg::SLOT_W-1:0]   rsp_slot_reg,     rsp_slot_next;

    logic                          req_fire;
    logic [MOD_W-1:0]              eff_div;
    logic [MOD_W-1:0]              pos_inc;
    logic [MOD_W-1:0]              pos_wrap;
    logic                          mod_done;
    logic [MOD_W-1:0]              mod_rem;

    // memory ports
    logic [IDX_W-1:0]              rd_addr;
    lpht_pkg::slot_state_t         rd_status;
    logic [lpht_pkg::KEY_W-1:0]    rd_key;
    logic [IDX_W-1:0]              wr_addr;
    lpht_pkg::slot_wr_t            wr;

    // probe decisions on the slot read last cycle
    logic                          hit_ins;
    logic                          hit_del;
    logic                          stop_empty;
    logic                          last_probe;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.status = rsp_status_reg;
    assign rsp.slot   = rsp_slot_reg;

    // effective divisor: zero acts as one, capped at the table depth
    always_comb
    begin
        eff_div = hash_modulus_reg;
        if (hash_modulus_reg == '0)
        begin
            eff_div = MOD_W'(1);
        end
        else if (32'(hash_modulus_reg) > TABLE_DEPTH)
        begin
            eff_div = MOD_W'(TABLE_DEPTH);
        end
    end

    // next probe position, wrapping at the divisor
    assign pos_inc  = MOD_W'(pos_reg + 1'b1);
    assign pos_wrap = (pos_inc == eff_div) ? '0 : pos_inc;

    assign hit_ins    = (cmd_reg == lpht_pkg::CMD_INSERT) &&
                        (rd_status != lpht_pkg::SLOT_USED);
    assign stop_empty = (cmd_reg == lpht_pkg::CMD_DELETE) &&
                        (rd_status == lpht_pkg::SLOT_EMPTY);
    assign hit_del    = (cmd_reg == lpht_pkg::CMD_DELETE) &&
                        (rd_status == lpht_pkg::SLOT_USED) && (rd_key == key_reg);
    assign last_probe = (cnt_reg == CNT_W'(TABLE_DEPTH - 1));

    lpht_mod_unit u_mod
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (req_fire),
        .key     (req.key),
        .divisor (eff_div),
        .done    (mod_done),
        .rem     (mod_rem)
    );

    // the write that ends an item is the last access of that item, and the
    // next item reads only after its remainder is done, so no forwarding
    lpht_slot_store
    #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    )
    u_store
    (
        .clk       (clk),
        .rd_addr   (rd_addr),
        .rd_status (rd_status),
        .rd_key    (rd_key),
        .wr_addr   (wr_addr),
        .wr        (wr),
        .wr_key    (key_reg)
    );

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pos_next        = pos_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_slot_next   = rsp_slot_reg;
        rd_addr         = IDX_W'(pos_reg);
        wr_addr         = IDX_W'(pos_reg);
        wr.we_status    = 1'b0;
        wr.we_key       = 1'b0;
        wr.status       = lpht_pkg::SLOT_EMPTY;

        case (state_reg)
            ST_CLEAR:
            begin
                // sweep the status memory to empty, one slot a cycle
                wr_addr      = IDX_W'(cnt_reg);
                wr.we_status = 1'b1;
                cnt_next     = CNT_W'(cnt_reg + 1'b1);
                if (last_probe)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // home slot read issued as soon as the remainder is out
                if (mod_done)
                begin
                    pos_next   = mod_rem;
                    rd_addr    = IDX_W'(mod_rem);
                    cnt_next   = '0;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (hit_ins)
                begin
                    wr.we_status    = 1'b1;
                    wr.we_key       = 1'b1;
                    wr.status       = lpht_pkg::SLOT_USED;
                    res_status_next = lpht_pkg::RES_INSERTED;
                    res_slot_next   = lpht_pkg::SLOT_W'(pos_reg);
                    state_next      = ST_DONE;
                end
                else if (hit_del)
                begin
                    wr.we_status    = 1'b1;
                    wr.status       = lpht_pkg::SLOT_GONE;
                    res_status_next = lpht_pkg::RES_DELETED;
                    res_slot_next   = lpht_pkg::SLOT_W'(pos_reg);
                    state_next      = ST_DONE;
                end
                else if (stop_empty || last_probe)
                begin
                    res_status_next = (cmd_reg == lpht_pkg::CMD_INSERT) ?
                                      lpht_pkg::RES_FULL : lpht_pkg::RES_MISSING;
                    res_slot_next   = '0;
                    state_next      = ST_DONE;
                end
                else
                begin
                    // keep streaming: read the next slot on the path
                    pos_next = pos_wrap;
                    rd_addr  = IDX_W'(pos_wrap);
                    cnt_next = CNT_W'(cnt_reg + 1'b1);
                end
            end
            ST_DONE:
            begin
                // hand the result over once the response register is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_slot_next   = res_slot_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            cnt_reg          <= '0;
            pos_reg          <= '0;
            hash_modulus_reg <= lpht_pkg::HASH_MODULUS_RESET;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                hash_modulus_reg <= cfg.hash_modulus;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            cmd_reg <= req.cmd;
            key_reg <= req.key;
        end
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        rsp_status_reg <= rsp_status_next;
        rsp_slot_reg   <= rsp_slot_next;
    end

    // memory writes come only from the clearing sweep or a landed probe
    a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.we_status || wr.we_key) |-> (state_reg == ST_CLEAR || state_reg == ST_PROBE))
        else $error("slot store written outside clear or probe");

    // probe position always lies below the effective divisor
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE) |-> (pos_reg < eff_div))
        else $error("probe position beyond divisor");

    // the remainder unit finishes only while the controller waits for it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (state_reg == ST_DIV))
        else $error("remainder done outside divide phase");

    // a new response only appears right after the result was staged
    a_rsp_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("response raised without a finished item");

endmodule

### sim/tb_linear_probe_hash_table_unit.sv
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_table_unit
// self-checking bench for the linear probing hash table unit
// ----------------------------------------------------------------------------
// Insert and delete items go in on the request channel. A shadow copy of the
// slot table predicts the status and slot of every accepted item, and each
// response is checked against the oldest prediction. The run goes through a
// directed part, then random phases under several divisor settings. Both
// sides of the datapath idle and stall at random.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_table_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 64;
    localparam logic [lpht_pkg::KEY_W-1:0] KEY_MAX = {lpht_pkg::KEY_W{1'b1}};

    // one request item and the response it should produce
    typedef struct packed
    {
        lpht_pkg::cmd_t                cmd;
        logic [lpht_pkg::KEY_W-1:0]    key;
    } probe_req_t;

    typedef struct packed
    {
        lpht_pkg::result_t             status;
        logic [lpht_pkg::SLOT_W-1:0]   slot;
    } table_outcome_t;

    logic clk = 1'b0;
    logic rst_n;

    lpht_req_if req_ch ();
    lpht_rsp_if rsp_ch ();
    lpht_cfg_if cfg_ch ();

    linear_probe_hash_table_unit
    #(
        .TABLE_DEPTH (TABLE_DEPTH)
    )
    uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // shadow of the table: stored keys, slot states, divisor register
    logic [lpht_pkg::KEY_W-1:0]    shadow_key [TABLE_DEPTH];
    lpht_pkg::slot_state_t         shadow_state [TABLE_DEPTH];
    logic [lpht_pkg::MOD_W-1:0]    shadow_modulus;

    probe_req_t                    pending_items [$];
    table_outcome_t                expected_outcomes [$];
    logic [lpht_pkg::KEY_W-1:0]    live_keys [$];

    probe_req_t next_req;
    table_outcome_t got_outcome;
    table_outcome_t want_outcome;
    logic req_taken = 1'b0;
    logic cfg_taken = 1'b0;
    bit   no_idle = 1'b0;
    int   items_queued = 0;
    int   results_seen = 0;
    int   err_count = 0;

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("mismatch at %0t ns: %s", $realtime, msg);
    endtask

    // divisor as the table uses it: zero acts as one, capped at the depth
    function automatic int unsigned effective_divisor(
        input logic [lpht_pkg::MOD_W-1:0] m);
        int unsigned d;
        d = m;
        if (d == 0)
            d = 1;
        if (d > TABLE_DEPTH)
            d = TABLE_DEPTH;
        return d;
    endfunction

    // walk the probe path in the shadow table and update it
    function automatic table_outcome_t apply_table_op(
        input lpht_pkg::cmd_t op,
        input logic [lpht_pkg::KEY_W-1:0] k);
        int unsigned div;
        int unsigned pos;
        table_outcome_t o;
        div = effective_divisor(shadow_modulus);
        pos = k % div;
        o.status = (op == lpht_pkg::CMD_INSERT) ? lpht_pkg::RES_FULL
                                                : lpht_pkg::RES_MISSING;
        o.slot = '0;
        for (int n = 0; n < TABLE_DEPTH; n++)
        begin
            if (op == lpht_pkg::CMD_INSERT)
            begin
                // first empty or deleted slot takes the key
                if (shadow_state[pos] != lpht_pkg::SLOT_USED)
                begin
                    shadow_key[pos] = k;
                    shadow_state[pos] = lpht_pkg::SLOT_USED;
                    o.status = lpht_pkg::RES_INSERTED;
                    o.slot = lpht_pkg::SLOT_W'(pos);
                    break;
                end
            end
            else
            begin
                // an empty slot ends the search, deleted slots are skipped
                if (shadow_state[pos] == lpht_pkg::SLOT_EMPTY)
                    break;
                if (shadow_state[pos] == lpht_pkg::SLOT_USED && shadow_key[pos] == k)
                begin
                    shadow_state[pos] = lpht_pkg::SLOT_GONE;
                    o.status = lpht_pkg::RES_DELETED;
                    o.slot = lpht_pkg::SLOT_W'(pos);
                    break;
                end
            end
            pos = (pos + 1) % div;
        end
        return o;
    endfunction

    // ------------------------------------------------------------------
    // request driver: holds an item until taken, idles at random
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && !(req_ch.valid && !req_taken))
        begin
            if (pending_items.size() != 0 && (no_idle || $urandom_range(0, 99) >= 16))
            begin
                next_req = pending_items.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.cmd <= next_req.cmd;
                req_ch.key <= next_req.key;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // response backpressure, about one cycle in six stalled
    always @(negedge clk)
    begin
        rsp_ch.ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 16);
    end

    // ------------------------------------------------------------------
    // monitor: track handshakes, predict on accept, check responses
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        req_taken <= req_ch.valid && req_ch.ready;
        cfg_taken <= cfg_ch.valid && cfg_ch.ready;
        if (rst_n)
        begin
            // register write lands before any later item is predicted
            if (cfg_ch.valid && cfg_ch.ready)
                shadow_modulus = cfg_ch.hash_modulus;
            if (req_ch.valid && req_ch.ready)
                expected_outcomes.push_back(apply_table_op(req_ch.cmd, req_ch.key));
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_seen++;
                got_outcome.status = rsp_ch.status;
                got_outcome.slot = rsp_ch.slot;
                if (expected_outcomes.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected response status %0d slot %0d",
                                              got_outcome.status, got_outcome.slot));
                end
                else
                begin
                    want_outcome = expected_outcomes.pop_front();
                    if (got_outcome.status !== want_outcome.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  got_outcome.status, want_outcome.status));
                    if (got_outcome.slot !== want_outcome.slot)
                        report_mismatch($sformatf("slot %0d, expected %0d",
                                                  got_outcome.slot, want_outcome.slot));
                end
            end
        end
    end

    task automatic push_item(input lpht_pkg::cmd_t op,
                             input logic [lpht_pkg::KEY_W-1:0] k);
        probe_req_t it;
        it.cmd = op;
        it.key = k;
        pending_items.push_back(it);
        items_queued++;
    endtask

    // wait until every queued item has produced its response
    task automatic wait_table_idle();
        do
            @(negedge clk);
        while (results_seen != items_queued);
    endtask

    task automatic write_modulus(input logic [lpht_pkg::MOD_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.hash_modulus <= value;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_ch.valid <= 1'b0;
    endtask

    // random phase: mostly keys that collide on the current divisor, deletes
    // aimed mostly at keys inserted earlier, plus full-width noise keys
    task automatic queue_random_items(input int count,
                                      input logic [lpht_pkg::MOD_W-1:0] m);
        int unsigned div;
        int unsigned pick;
        logic [lpht_pkg::KEY_W-1:0] k;
        lpht_pkg::cmd_t op;
        div = effective_divisor(m);
        for (int i = 0; i < count; i++)
        begin
            op = ($urandom_range(0, 99) < 55) ? lpht_pkg::CMD_INSERT
                                              : lpht_pkg::CMD_DELETE;
            pick = $urandom_range(0, 99);
            if (op == lpht_pkg::CMD_DELETE && live_keys.size() != 0 && pick < 70)
                k = live_keys[$urandom_range(0, live_keys.size() - 1)];
            else if (op == lpht_pkg::CMD_INSERT && live_keys.size() != 0 && pick < 20)
                k = live_keys[$urandom_range(0, live_keys.size() - 1)];
            else if (pick < 65)
                k = lpht_pkg::KEY_W'($urandom_range(0, 4 * div));
            else if (pick < 70)
                k = KEY_MAX - lpht_pkg::KEY_W'($urandom_range(0, 3));
            else
                k = lpht_pkg::KEY_W'($urandom);
            if (op == lpht_pkg::CMD_INSERT)
            begin
                live_keys.push_back(k);
                if (live_keys.size() > 128)
                    void'(live_keys.pop_front());
            end
            push_item(op, k);
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [lpht_pkg::MOD_W-1:0] phase_modulus [7];
        phase_modulus = '{7'd64, 7'd5, 7'd1, 7'd37, 7'd100, 7'd63, 7'd64};

        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.cmd = lpht_pkg::CMD_INSERT;
        req_ch.key = '0;
        rsp_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.hash_modulus = lpht_pkg::HASH_MODULUS_RESET;
        shadow_modulus = lpht_pkg::HASH_MODULUS_RESET;
        foreach (shadow_state[i])
        begin
            shadow_state[i] = lpht_pkg::SLOT_EMPTY;
            shadow_key[i] = '0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset divisor of 64: home slots, collision, wrap, deleted markers
        push_item(lpht_pkg::CMD_INSERT, '0);
        push_item(lpht_pkg::CMD_INSERT, KEY_MAX);            // largest key homes to slot 63
        push_item(lpht_pkg::CMD_INSERT, lpht_pkg::KEY_W'(64));   // collides with key 0
        push_item(lpht_pkg::CMD_INSERT, lpht_pkg::KEY_W'(64));   // duplicate goes in again
        push_item(lpht_pkg::CMD_DELETE, '0);
        push_item(lpht_pkg::CMD_DELETE, lpht_pkg::KEY_W'(64));   // probes past a deleted slot
        push_item(lpht_pkg::CMD_DELETE, lpht_pkg::KEY_W'(5));    // empty home slot
        push_item(lpht_pkg::CMD_INSERT, lpht_pkg::KEY_W'(128));  // reuses the deleted slot
        push_item(lpht_pkg::CMD_DELETE, lpht_pkg::KEY_W'(127));  // wraps from 63 to 0
        wait_table_idle();

        // divisor zero acts as one: everything lands on slot 0
        write_modulus(7'd0);
        push_item(lpht_pkg::CMD_INSERT, lpht_pkg::KEY_W'(5));    // table full
        push_item(lpht_pkg::CMD_DELETE, lpht_pkg::KEY_W'(128));
        push_item(lpht_pkg::CMD_DELETE, lpht_pkg::KEY_W'(9));    // full probe over a deleted slot
        push_item(lpht_pkg::CMD_INSERT, lpht_pkg::KEY_W'(9));
        push_item(lpht_pkg::CMD_DELETE, KEY_MAX);
        wait_table_idle();

        // divisor above the depth is capped
        write_modulus(7'd127);
        push_item(lpht_pkg::CMD_INSERT, KEY_MAX);
        push_item(lpht_pkg::CMD_INSERT, lpht_pkg::KEY_W'(9));
        push_item(lpht_pkg::CMD_DELETE, lpht_pkg::KEY_W'(64));
        push_item(lpht_pkg::CMD_DELETE, KEY_MAX);
        push_item(lpht_pkg::CMD_INSERT, lpht_pkg::KEY_W'(32'h2AAA_AAAA));
        push_item(lpht_pkg::CMD_INSERT, lpht_pkg::KEY_W'(32'h5555_5555));
        wait_table_idle();

        // random phases, one of them with no idling on either side
        for (int p = 0; p < 7; p++)
        begin
            write_modulus(phase_modulus[p]);
            no_idle = (p == 3);
            queue_random_items(125, phase_modulus[p]);
            wait_table_idle();
        end
        no_idle = 1'b0;

        // drain: allow the engine a full probe length to show anything stray
        repeat (TABLE_DEPTH + 40) @(posedge clk);
        if (err_count == 0 && expected_outcomes.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

### filelist.f
sv/lpht_pkg.sv
sv/lpht_ifs.sv
sv/lpht_mod_unit.sv
sv/lpht_slot_store.sv
sv/linear_probe_hash_table_unit.sv
sim/tb_linear_probe_hash_table_unit.sv
